// ===== src/lsis_pkg.sv =====
// Shared types and constants for the lattice species interaction block.
package lsis_pkg;

    localparam int CELL_W     = 3;
    localparam int CNT_W      = 17;
    localparam int TOTAL_W    = 32;
    localparam int PROB_W     = 16;
    localparam int NUM_VALUES = 5;
    localparam int FIELD_SPAN = 256;

    localparam logic [CELL_W-1:0] CELL_EMPTY  = 3'd0;
    localparam logic [CELL_W-1:0] MAX_SPECIES = 3'd4;

    localparam logic [PROB_W-1:0] MOB_RESET   = 16'd32768;
    localparam logic [PROB_W-1:0] PRED_RESET  = 16'd16384;
    localparam logic [PROB_W-1:0] TABLE_RESET = 16'd14790;

    typedef enum logic [1:0] {
        OP_INTERACT = 2'd0,
        OP_WRITE    = 2'd1,
        OP_READ     = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        DIR_ROW_UP   = 2'd0,
        DIR_ROW_DOWN = 2'd1,
        DIR_COL_UP   = 2'd2,
        DIR_COL_DOWN = 2'd3
    } t_dir;

    typedef enum logic [1:0] {
        CFG_MOBILITY  = 2'd0,
        CFG_PREDATION = 2'd1,
        CFG_TABLE     = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OUT_IGNORED = 3'd0,
        OUT_MOVE    = 3'd1,
        OUT_KILL    = 3'd2,
        OUT_BIRTH   = 3'd3,
        OUT_NONE    = 3'd4,
        OUT_ACCESS  = 3'd5
    } t_outcome;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SWAP,
        ST_POST
    } t_state;

    // Update plan for one item, from the rule logic to the sequencer
    typedef struct packed {
        t_outcome            outcome;
        logic [CELL_W-1:0]   cell_value;
        logic                wr_en;
        logic                wr_pas;
        logic [CELL_W-1:0]   wr_data;
        logic                swap;
        logic                pop_chg;
        logic [CELL_W-1:0]   pop_from;
        logic [CELL_W-1:0]   pop_to;
        logic                is_move;
        logic                is_kill;
        logic                is_birth;
    } t_plan;

endpackage

// ===== src/lattice_species_interaction_step.sv =====
// Top level of the lattice species interaction block: sequencer, counters, I/O.
//
// Input channel (i_in_valid / o_in_stall) carries one item per beat: an
// interact, a cell write or a cell read. Output channel (o_out_valid /
// i_out_stall) returns one result beat per item, with the cell contents, the
// five population counts and the running totals after that item.
// Configuration registers are written through i_cfg_we / i_cfg_index /
// i_cfg_data; index 3 is ignored. The user must write them only while the
// block is idle; the block itself does not enforce this. Timing: the grid
// lives in one memory with one write port and two read ports. The beat
// accept edge also reads the active and neighbor cells; the next cycle
// applies the rules and writes at most one cell. A mobility swap needs a
// second write, in ST_SWAP. The result is loaded into the output register
// along with the last write, or from ST_POST once that register frees up.
// Reset clears the counters and restores the register defaults, then sweeps
// the grid to empty, one cell a cycle, with o_in_stall high. A result waiting
// under i_out_stall holds its payload; the next item is accepted and worked
// on meanwhile, and its own result waits until the output register frees up.
module lattice_species_interaction_step #(
    parameter int ROWS = 256,
    parameter int COLS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_row,
    input  logic [7:0]  i_col,
    input  logic [1:0]  i_direction,
    input  logic [15:0] i_action_draw,
    input  logic [2:0]  i_new_value,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_outcome,
    output logic [2:0]  o_cell_value,
    output logic [16:0] o_count_empty,
    output logic [16:0] o_count_first,
    output logic [16:0] o_count_second,
    output logic [16:0] o_count_third,
    output logic [16:0] o_count_fourth,
    output logic        o_sweep_done,
    output logic [31:0] o_sweep_count,
    output logic [31:0] o_total_moves,
    output logic [31:0] o_total_kills,
    output logic [31:0] o_total_births,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int PW    = $clog2(CELLS);
    localparam int CW    = lsis_pkg::CELL_W;
    localparam int NW    = lsis_pkg::CNT_W;
    localparam int TW    = lsis_pkg::TOTAL_W;
    localparam int NV    = lsis_pkg::NUM_VALUES;

    lsis_pkg::t_state r_state, n_state;

    // configuration registers
    logic [15:0] r_mob, r_pred, r_tab;

    // item registers
    logic [1:0]    r_op;
    logic [15:0]   r_draw;
    logic [CW-1:0] r_nv;
    logic [AW-1:0] r_act, r_pas;

    // clear sweep
    logic [AW-1:0] r_clr;

    // running state
    logic [NW-1:0] r_pop [NV];
    logic [NW-1:0] n_pop [NV];
    logic [PW-1:0] r_prog, n_prog;
    logic [TW-1:0] r_sweeps, n_sweeps;
    logic [TW-1:0] r_moves, n_moves;
    logic [TW-1:0] r_kills, n_kills;
    logic [TW-1:0] r_births, n_births;

    // per-item result, held until it reaches the output register
    lsis_pkg::t_outcome r_res_outcome, n_res_outcome;
    logic [CW-1:0]      r_res_value, n_res_value;
    logic               r_res_done, n_res_done;

    // output register
    logic               r_out_valid;
    lsis_pkg::t_outcome r_out_outcome;
    logic [CW-1:0]      r_out_value;
    logic [NW-1:0]      r_out_pop [NV];
    logic               r_out_done;
    logic [TW-1:0]      r_out_sweeps, r_out_moves, r_out_kills, r_out_births;

    // memory and datapath
    logic [AW-1:0]   in_act, in_pas;
    logic [CW-1:0]   rd_act, rd_pas;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [CW-1:0]   mem_wdata;
    lsis_pkg::t_plan plan;
    logic            in_accept;
    logic            out_free;
    logic            out_load;
    logic            exec;
    logic            success;
    logic            last_clr;

    lsis_addr #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_addr (
        .i_row       (i_row),
        .i_col       (i_col),
        .i_direction (i_direction),
        .o_act_addr  (in_act),
        .o_pas_addr  (in_pas)
    );

    lsis_grid_mem #(
        .DEPTH (CELLS)
    ) u_grid (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_re      (in_accept),
        .i_raddr_a (in_act),
        .i_raddr_b (in_pas),
        .o_rdata_a (rd_act),
        .o_rdata_b (rd_pas)
    );

    lsis_rule u_rule (
        .i_operation       (r_op),
        .i_act_val         (rd_act),
        .i_pas_val         (rd_pas),
        .i_action_draw     (r_draw),
        .i_new_value       (r_nv),
        .i_mobility_prob   (r_mob),
        .i_predation_prob  (r_pred),
        .i_predation_table (r_tab),
        .o_plan            (plan)
    );

    assign o_in_stall = (r_state != lsis_pkg::ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign exec       = (r_state == lsis_pkg::ST_EXEC);
    assign last_clr   = (r_clr == AW'(CELLS - 1));

    // sequencer: next state, grid write port, output load
    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_waddr = r_act;
        mem_wdata = plan.wr_data;
        out_load  = 1'b0;
        unique case (r_state)
            lsis_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = lsis_pkg::CELL_EMPTY;
                if (last_clr) begin
                    n_state = lsis_pkg::ST_IDLE;
                end
            end
            lsis_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = lsis_pkg::ST_EXEC;
                end
            end
            lsis_pkg::ST_EXEC: begin
                mem_we    = plan.wr_en;
                mem_waddr = plan.wr_pas ? r_pas : r_act;
                if (plan.swap) begin
                    n_state = lsis_pkg::ST_SWAP;
                end else if (out_free) begin
                    out_load = 1'b1;
                    n_state  = lsis_pkg::ST_IDLE;
                end else begin
                    n_state = lsis_pkg::ST_POST;
                end
            end
            lsis_pkg::ST_SWAP: begin
                // second half of the swap: active cell takes the neighbor value
                mem_we    = 1'b1;
                mem_waddr = r_act;
                mem_wdata = rd_pas;
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = lsis_pkg::ST_IDLE;
                end else begin
                    n_state = lsis_pkg::ST_POST;
                end
            end
            lsis_pkg::ST_POST: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = lsis_pkg::ST_IDLE;
                end
            end
            default: n_state = lsis_pkg::ST_IDLE;
        endcase
    end

    // post-item values; outside of the execute cycle they equal the registers
    assign success = exec && (plan.is_move || plan.is_kill || plan.is_birth);

    always_comb begin
        for (int k = 0; k < NV; k++) begin
            n_pop[k] = r_pop[k];
            if (exec && plan.pop_chg) begin
                n_pop[k] = r_pop[k]
                    + NW'(plan.pop_to == CW'(k))
                    - NW'(plan.pop_from == CW'(k));
            end
        end
    end

    always_comb begin
        n_prog     = r_prog;
        n_sweeps   = r_sweeps;
        n_res_done = exec ? 1'b0 : r_res_done;
        if (success) begin
            if (r_prog == PW'(CELLS - 1)) begin
                n_prog     = '0;
                n_sweeps   = r_sweeps + 1'b1;
                n_res_done = 1'b1;
            end else begin
                n_prog = r_prog + 1'b1;
            end
        end
    end

    assign n_moves       = r_moves  + TW'(exec && plan.is_move);
    assign n_kills       = r_kills  + TW'(exec && plan.is_kill);
    assign n_births      = r_births + TW'(exec && plan.is_birth);
    assign n_res_outcome = exec ? plan.outcome : r_res_outcome;
    assign n_res_value   = exec ? plan.cell_value : r_res_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsis_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // control and running state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_mob       <= lsis_pkg::MOB_RESET;
            r_pred      <= lsis_pkg::PRED_RESET;
            r_tab       <= lsis_pkg::TABLE_RESET;
            r_prog      <= '0;
            r_sweeps    <= '0;
            r_moves     <= '0;
            r_kills     <= '0;
            r_births    <= '0;
            r_out_valid <= 1'b0;
            r_res_done  <= 1'b0;
            for (int k = 0; k < NV; k++) begin
                r_pop[k] <= (k == 0) ? NW'(CELLS) : '0;
            end
        end else begin
            if (r_state == lsis_pkg::ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_we) begin
                unique case (lsis_pkg::t_cfg_idx'(i_cfg_index))
                    lsis_pkg::CFG_MOBILITY:  r_mob  <= i_cfg_data;
                    lsis_pkg::CFG_PREDATION: r_pred <= i_cfg_data;
                    lsis_pkg::CFG_TABLE:     r_tab  <= i_cfg_data;
                    default: ;
                endcase
            end
            r_prog     <= n_prog;
            r_sweeps   <= n_sweeps;
            r_moves    <= n_moves;
            r_kills    <= n_kills;
            r_births   <= n_births;
            r_res_done <= n_res_done;
            for (int k = 0; k < NV; k++) begin
                r_pop[k] <= n_pop[k];
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op   <= i_operation;
            r_draw <= i_action_draw;
            r_nv   <= i_new_value;
            r_act  <= in_act;
            r_pas  <= in_pas;
        end
        r_res_outcome <= n_res_outcome;
        r_res_value   <= n_res_value;
        if (out_load) begin
            r_out_outcome <= n_res_outcome;
            r_out_value   <= n_res_value;
            r_out_done    <= n_res_done;
            r_out_sweeps  <= n_sweeps;
            r_out_moves   <= n_moves;
            r_out_kills   <= n_kills;
            r_out_births  <= n_births;
            for (int k = 0; k < NV; k++) begin
                r_out_pop[k] <= n_pop[k];
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_outcome      = r_out_outcome;
    assign o_cell_value   = r_out_value;
    assign o_count_empty  = r_out_pop[0];
    assign o_count_first  = r_out_pop[1];
    assign o_count_second = r_out_pop[2];
    assign o_count_third  = r_out_pop[3];
    assign o_count_fourth = r_out_pop[4];
    assign o_sweep_done   = r_out_done;
    assign o_sweep_count  = r_out_sweeps;
    assign o_total_moves  = r_out_moves;
    assign o_total_kills  = r_out_kills;
    assign o_total_births = r_out_births;

endmodule

// ===== src/lsis_grid_mem.sv =====
// Grid memory: one write port, two registered read ports.
module lsis_grid_mem #(
    parameter int DEPTH = 65536,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [lsis_pkg::CELL_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr_a,
    input  logic [AW-1:0]             i_raddr_b,
    output logic [lsis_pkg::CELL_W-1:0] o_rdata_a,
    output logic [lsis_pkg::CELL_W-1:0] o_rdata_b
);

    logic [lsis_pkg::CELL_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= mem[i_raddr_a];
            o_rdata_b <= mem[i_raddr_b];
        end
    end

endmodule

// ===== src/lsis_addr.sv =====
// Address unit: folds row and column into the grid and finds the neighbor cell.
module lsis_addr #(
    parameter int ROWS = 256,
    parameter int COLS = 256,
    localparam int RW = $clog2(ROWS),
    localparam int CW = $clog2(COLS),
    localparam int AW = $clog2(ROWS * COLS)
) (
    input  logic [7:0]    i_row,
    input  logic [7:0]    i_col,
    input  logic [1:0]    i_direction,
    output logic [AW-1:0] o_act_addr,
    output logic [AW-1:0] o_pas_addr
);

    logic [RW-1:0] row_mod [lsis_pkg::FIELD_SPAN];
    logic [CW-1:0] col_mod [lsis_pkg::FIELD_SPAN];
    logic [RW-1:0] r;
    logic [CW-1:0] c;
    logic [RW-1:0] nr;
    logic [CW-1:0] nc;

    // Constant tables for row % ROWS and col % COLS
    for (genvar g = 0; g < lsis_pkg::FIELD_SPAN; g++) begin : g_mod
        assign row_mod[g] = RW'(g % ROWS);
        assign col_mod[g] = CW'(g % COLS);
    end

    assign r = row_mod[i_row];
    assign c = col_mod[i_col];

    always_comb begin
        nr = r;
        nc = c;
        unique case (lsis_pkg::t_dir'(i_direction))
            lsis_pkg::DIR_ROW_UP:   nr = (r == RW'(ROWS - 1)) ? '0 : r + 1'b1;
            lsis_pkg::DIR_ROW_DOWN: nr = (r == '0) ? RW'(ROWS - 1) : r - 1'b1;
            lsis_pkg::DIR_COL_UP:   nc = (c == CW'(COLS - 1)) ? '0 : c + 1'b1;
            lsis_pkg::DIR_COL_DOWN: nc = (c == '0) ? CW'(COLS - 1) : c - 1'b1;
            default: ;
        endcase
    end

    assign o_act_addr = AW'(r) * AW'(COLS) + AW'(c);
    assign o_pas_addr = AW'(nr) * AW'(COLS) + AW'(nc);

endmodule

// ===== src/lsis_rule.sv =====
// Interaction rules: decide outcome, grid writes and count changes for one item.
module lsis_rule (
    input  logic [1:0]                  i_operation,
    input  logic [lsis_pkg::CELL_W-1:0] i_act_val,
    input  logic [lsis_pkg::CELL_W-1:0] i_pas_val,
    input  logic [lsis_pkg::PROB_W-1:0] i_action_draw,
    input  logic [lsis_pkg::CELL_W-1:0] i_new_value,
    input  logic [lsis_pkg::PROB_W-1:0] i_mobility_prob,
    input  logic [lsis_pkg::PROB_W-1:0] i_predation_prob,
    input  logic [lsis_pkg::PROB_W-1:0] i_predation_table,
    output lsis_pkg::t_plan             o_plan
);

    logic [lsis_pkg::PROB_W:0]   pred_limit;
    logic [lsis_pkg::CELL_W-1:0] a_m1;
    logic [lsis_pkg::CELL_W-1:0] b_m1;
    logic [3:0]                  pred_bit;

    assign pred_limit = {1'b0, i_mobility_prob} + {1'b0, i_predation_prob};
    assign a_m1       = i_act_val - 1'b1;
    assign b_m1       = i_pas_val - 1'b1;
    assign pred_bit   = {a_m1[1:0], b_m1[1:0]};

    always_comb begin
        o_plan            = '0;
        o_plan.outcome    = lsis_pkg::OUT_ACCESS;
        o_plan.cell_value = i_act_val;
        case (lsis_pkg::t_op'(i_operation))
            lsis_pkg::OP_WRITE: begin
                // drop writes of codes above the last species
                if (i_new_value <= lsis_pkg::MAX_SPECIES) begin
                    o_plan.wr_en      = 1'b1;
                    o_plan.wr_data    = i_new_value;
                    o_plan.pop_chg    = 1'b1;
                    o_plan.pop_from   = i_act_val;
                    o_plan.pop_to     = i_new_value;
                    o_plan.cell_value = i_new_value;
                end
            end
            lsis_pkg::OP_INTERACT: begin
                if (i_act_val == lsis_pkg::CELL_EMPTY) begin
                    o_plan.outcome = lsis_pkg::OUT_IGNORED;
                end else if (i_action_draw < i_mobility_prob) begin
                    // swap: neighbor now, active cell on the next write
                    o_plan.outcome    = lsis_pkg::OUT_MOVE;
                    o_plan.wr_en      = 1'b1;
                    o_plan.wr_pas     = 1'b1;
                    o_plan.wr_data    = i_act_val;
                    o_plan.swap       = 1'b1;
                    o_plan.cell_value = i_pas_val;
                    o_plan.is_move    = 1'b1;
                end else if ({1'b0, i_action_draw} <= pred_limit) begin
                    if (i_pas_val != lsis_pkg::CELL_EMPTY && i_predation_table[pred_bit]) begin
                        o_plan.outcome  = lsis_pkg::OUT_KILL;
                        o_plan.wr_en    = 1'b1;
                        o_plan.wr_pas   = 1'b1;
                        o_plan.wr_data  = lsis_pkg::CELL_EMPTY;
                        o_plan.pop_chg  = 1'b1;
                        o_plan.pop_from = i_pas_val;
                        o_plan.pop_to   = lsis_pkg::CELL_EMPTY;
                        o_plan.is_kill  = 1'b1;
                    end else begin
                        o_plan.outcome = lsis_pkg::OUT_NONE;
                    end
                end else if (i_pas_val == lsis_pkg::CELL_EMPTY) begin
                    o_plan.outcome  = lsis_pkg::OUT_BIRTH;
                    o_plan.wr_en    = 1'b1;
                    o_plan.wr_pas   = 1'b1;
                    o_plan.wr_data  = i_act_val;
                    o_plan.pop_chg  = 1'b1;
                    o_plan.pop_from = lsis_pkg::CELL_EMPTY;
                    o_plan.pop_to   = i_act_val;
                    o_plan.is_birth = 1'b1;
                end else begin
                    o_plan.outcome = lsis_pkg::OUT_NONE;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the lattice species interaction block.
module tb;
    import lsis_pkg::*;

    localparam int     ROWS          = 256;
    localparam int     COLS          = 256;
    localparam int     CELLS         = ROWS * COLS;
    localparam int     RANDOM_ITEMS  = 1500;
    localparam int     PHASE_COUNT   = 6;
    localparam int     SETTLE_CYCLES = 4;
    localparam int     DRAIN_LIMIT   = 20000;
    localparam int     PRINT_CAP     = 60;
    // Bound on the clearing pass plus the random run with long gaps on both sides.
    localparam longint CYCLE_LIMIT   = 3_000_000;

    // Codes the package enums do not cover
    localparam logic [1:0] OP_READ_ALIAS = 2'd3;   // undefined opcode, acts as a read
    localparam logic [1:0] CFG_SPARE     = 2'd3;   // unused register index

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [1:0]  dir;
        logic [15:0] draw;
        logic [2:0]  value;
    } t_item;

    typedef struct packed {
        t_outcome    outcome;
        logic [2:0]  cell_val;
        logic [16:0] n_empty;
        logic [16:0] n_first;
        logic [16:0] n_second;
        logic [16:0] n_third;
        logic [16:0] n_fourth;
        logic        sweep_done;
        logic [31:0] sweeps;
        logic [31:0] moves;
        logic [31:0] kills;
        logic [31:0] births;
    } t_snapshot;

    // ------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_operation;
    logic [7:0]  i_row;
    logic [7:0]  i_col;
    logic [1:0]  i_direction;
    logic [15:0] i_action_draw;
    logic [2:0]  i_new_value;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_outcome;
    logic [2:0]  o_cell_value;
    logic [16:0] o_count_empty;
    logic [16:0] o_count_first;
    logic [16:0] o_count_second;
    logic [16:0] o_count_third;
    logic [16:0] o_count_fourth;
    logic        o_sweep_done;
    logic [31:0] o_sweep_count;
    logic [31:0] o_total_moves;
    logic [31:0] o_total_kills;
    logic [31:0] o_total_births;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    lattice_species_interaction_step #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_direction    (i_direction),
        .i_action_draw  (i_action_draw),
        .i_new_value    (i_new_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_outcome      (o_outcome),
        .o_cell_value   (o_cell_value),
        .o_count_empty  (o_count_empty),
        .o_count_first  (o_count_first),
        .o_count_second (o_count_second),
        .o_count_third  (o_count_third),
        .o_count_fourth (o_count_fourth),
        .o_sweep_done   (o_sweep_done),
        .o_sweep_count  (o_sweep_count),
        .o_total_moves  (o_total_moves),
        .o_total_kills  (o_total_kills),
        .o_total_births (o_total_births),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Lattice predictor state: grid copy, population, totals, registers
    // ------------------------------------------------------------------
    logic [2:0]  lat_grid [CELLS];
    int unsigned lat_pop [5];
    int unsigned lat_progress;
    int unsigned lat_sweeps;
    int unsigned lat_moves;
    int unsigned lat_kills;
    int unsigned lat_births;
    logic [15:0] reg_mobility;
    logic [15:0] reg_predation;
    logic [15:0] reg_table;

    t_snapshot   pending_q [$];     // predicted result beats, oldest first
    int          err_count = 0;
    longint      cycle_count = 0;
    logic        idle_on = 1'b0;    // random gaps on both channels when set

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case the handshake hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d beats still pending",
                     cycle_count, pending_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report(input string msg);
        err_count++;
        if (err_count <= PRINT_CAP)
            $display("ERROR cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void lattice_clear();
        foreach (lat_grid[k]) lat_grid[k] = CELL_EMPTY;
        foreach (lat_pop[k]) lat_pop[k] = 0;
        lat_pop[0]    = CELLS;
        lat_progress  = 0;
        lat_sweeps    = 0;
        lat_moves     = 0;
        lat_kills     = 0;
        lat_births    = 0;
        reg_mobility  = MOB_RESET;
        reg_predation = PRED_RESET;
        reg_table     = TABLE_RESET;
    endfunction

    // Overwrite one cell and keep the population counts in step
    function automatic void place_cell(input int unsigned idx, input logic [2:0] v);
        lat_pop[lat_grid[idx] % 5]--;
        lat_pop[v % 5]++;
        lat_grid[idx] = v;
    endfunction

    function automatic t_snapshot lattice_apply(input t_item it);
        int unsigned r, c, nr, nc, act, pas, bit_pos, pred_lim;
        logic [2:0]  a, b;
        logic        done;
        t_outcome    res;
        t_snapshot   snap;
        r    = it.row % ROWS;
        c    = it.col % COLS;
        nr   = r;
        nc   = c;
        act  = r * COLS + c;
        res  = OUT_ACCESS;
        done = 1'b0;
        if (it.op == OP_WRITE) begin
            // values above the last species leave the cell alone
            if (it.value <= MAX_SPECIES) place_cell(act, it.value);
        end else if (it.op == OP_INTERACT) begin
            case (it.dir)
                DIR_ROW_UP:   nr = (r + 1) % ROWS;
                DIR_ROW_DOWN: nr = (r + ROWS - 1) % ROWS;
                DIR_COL_UP:   nc = (c + 1) % COLS;
                default:      nc = (c + COLS - 1) % COLS;
            endcase
            pas      = nr * COLS + nc;
            a        = lat_grid[act];
            b        = lat_grid[pas];
            pred_lim = reg_mobility + reg_predation;
            if (a == CELL_EMPTY) begin
                res = OUT_IGNORED;
            end else if (it.draw < reg_mobility) begin
                // swap counts even when the neighbor is empty
                lat_grid[pas] = a;
                lat_grid[act] = b;
                res = OUT_MOVE;
                lat_moves++;
            end else if (it.draw <= pred_lim) begin
                bit_pos = ((int'(a) - 1) & 3) * 4 + ((int'(b) - 1) & 3);
                if (b != CELL_EMPTY && reg_table[bit_pos]) begin
                    place_cell(pas, CELL_EMPTY);
                    res = OUT_KILL;
                    lat_kills++;
                end else begin
                    res = OUT_NONE;
                end
            end else if (b == CELL_EMPTY) begin
                place_cell(pas, a);
                res = OUT_BIRTH;
                lat_births++;
            end else begin
                res = OUT_NONE;
            end
            if (res == OUT_MOVE || res == OUT_KILL || res == OUT_BIRTH) begin
                lat_progress++;
                if (lat_progress >= CELLS) begin
                    lat_progress = 0;
                    lat_sweeps++;
                    done = 1'b1;
                end
            end
        end
        snap.outcome    = res;
        snap.cell_val   = lat_grid[act];
        snap.n_empty    = 17'(lat_pop[0]);
        snap.n_first    = 17'(lat_pop[1]);
        snap.n_second   = 17'(lat_pop[2]);
        snap.n_third    = 17'(lat_pop[3]);
        snap.n_fourth   = 17'(lat_pop[4]);
        snap.sweep_done = done;
        snap.sweeps     = lat_sweeps;
        snap.moves      = lat_moves;
        snap.kills      = lat_kills;
        snap.births     = lat_births;
        return snap;
    endfunction

    // ------------------------------------------------------------------
    // Pacing: mostly short gaps, a few long ones, none while idle_on is low
    // ------------------------------------------------------------------
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (!idle_on || pick < 55) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result-side stall generator
    initial begin : out_pacer
        int hold;
        hold = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (i_out_stall) begin
                // release, then stay open for a while
                i_out_stall <= 1'b0;
                hold = $urandom_range(0, 6);
            end else begin
                hold = gap_len();
                if (hold > 0) begin
                    i_out_stall <= 1'b1;
                    hold--;
                end
            end
        end
    end

    // Compare each accepted result beat with the oldest prediction
    always @(posedge i_clk) begin : result_monitor
        t_snapshot want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_q.size() == 0) begin
                report("result beat with no prediction pending");
            end else begin
                want = pending_q.pop_front();
                check_field("outcome", o_outcome, want.outcome);
                check_field("cell_value", o_cell_value, want.cell_val);
                check_field("count_empty", o_count_empty, want.n_empty);
                check_field("count_first", o_count_first, want.n_first);
                check_field("count_second", o_count_second, want.n_second);
                check_field("count_third", o_count_third, want.n_third);
                check_field("count_fourth", o_count_fourth, want.n_fourth);
                check_field("sweep_done", o_sweep_done, want.sweep_done);
                check_field("sweep_count", o_sweep_count, want.sweeps);
                check_field("total_moves", o_total_moves, want.moves);
                check_field("total_kills", o_total_kills, want.kills);
                check_field("total_births", o_total_births, want.births);
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    function automatic t_item make_item(input logic [1:0] op, input logic [7:0] row,
                                        input logic [7:0] col, input logic [1:0] dir,
                                        input logic [15:0] draw, input logic [2:0] value);
        t_item it;
        it.op    = op;
        it.row   = row;
        it.col   = col;
        it.dir   = dir;
        it.draw  = draw;
        it.value = value;
        return it;
    endfunction

    // Present one beat, hold it until accepted, then predict its result.
    // Leave valid high when no gap follows, so the next beat goes back to back.
    task automatic send_item(input t_item it, output t_outcome got);
        t_snapshot snap;
        int        gap;
        i_in_valid    <= 1'b1;
        i_operation   <= it.op;
        i_row         <= it.row;
        i_col         <= it.col;
        i_direction   <= it.dir;
        i_action_draw <= it.draw;
        i_new_value   <= it.value;
        do @(posedge i_clk); while (o_in_stall);
        snap = lattice_apply(it);
        pending_q.push_back(snap);
        got = snap.outcome;
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and hold off until every predicted beat has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MOBILITY:  reg_mobility  = data;
            CFG_PREDATION: reg_predation = data;
            CFG_TABLE:     reg_table     = data;
            default:       ;
        endcase
        @(posedge i_clk);
    endtask

    // Random beat, mostly inside a small hot window so cells meet each other;
    // the window offset wraps through the 8-bit address like the torus does.
    function automatic t_item random_item(input logic [7:0] hot_r, input logic [7:0] hot_c);
        t_item       it;
        int          sel;
        int unsigned pred_lim;
        if ($urandom_range(0, 99) < 85) begin
            it.row = hot_r + 8'($urandom_range(0, 3));
            it.col = hot_c + 8'($urandom_range(0, 3));
        end else begin
            it.row = 8'($urandom_range(0, 255));
            it.col = 8'($urandom_range(0, 255));
        end
        sel = $urandom_range(0, 99);
        if (sel < 62)      it.op = OP_INTERACT;
        else if (sel < 90) it.op = OP_WRITE;
        else if (sel < 95) it.op = OP_READ;
        else               it.op = OP_READ_ALIAS;
        it.dir   = 2'($urandom_range(0, 3));
        it.value = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
        pred_lim = reg_mobility + reg_predation;
        sel = $urandom_range(0, 99);
        // aim at the action thresholds now and then
        if (sel < 85)      it.draw = 16'($urandom_range(0, 65535));
        else if (sel < 89) it.draw = reg_mobility;
        else if (sel < 93) it.draw = reg_mobility - 16'd1;
        else if (sel < 97) it.draw = 16'(pred_lim);
        else               it.draw = 16'(pred_lim + 1);
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Plain reads and writes: empty grid after reset, address extremes,
    // ignored writes of out-of-range values, undefined opcode as read.
    task automatic test_cell_access();
        t_outcome got;
        send_item(make_item(OP_READ, 8'd0, 8'd0, DIR_ROW_UP, 16'd0, 3'd0), got);
        send_item(make_item(OP_WRITE, 8'd255, 8'd255, DIR_COL_DOWN, 16'hFFFF, 3'd4), got);
        send_item(make_item(OP_WRITE, 8'd0, 8'd0, DIR_ROW_UP, 16'd0, 3'd1), got);
        send_item(make_item(OP_WRITE, 8'd0, 8'd1, DIR_ROW_UP, 16'd0, 3'd7), got);
        send_item(make_item(OP_WRITE, 8'd0, 8'd1, DIR_ROW_UP, 16'd0, 3'd5), got);
        send_item(make_item(OP_READ_ALIAS, 8'd255, 8'd255, DIR_ROW_UP, 16'd0, 3'd7), got);
        send_item(make_item(OP_WRITE, 8'd0, 8'd1, DIR_ROW_UP, 16'd0, 3'd2), got);
        send_item(make_item(OP_WRITE, 8'd1, 8'd0, DIR_ROW_UP, 16'd0, 3'd3), got);
    endtask

    // Every interaction outcome under the reset probabilities: moves below
    // one half, predation up to three quarters inclusive, births above.
    task automatic test_interact_directed();
        t_outcome got;
        // empty active cell
        send_item(make_item(OP_INTERACT, 8'd5, 8'd5, DIR_ROW_UP, 16'd40000, 3'd0), got);
        // species 1 eats species 2
        send_item(make_item(OP_INTERACT, 8'd0, 8'd0, DIR_COL_UP, 16'd40000, 3'd0), got);
        // predation at the upper threshold on an empty neighbor
        send_item(make_item(OP_INTERACT, 8'd0, 8'd0, DIR_COL_UP, 16'd49152, 3'd0), got);
        // birth just above the threshold, then blocked by the newborn
        send_item(make_item(OP_INTERACT, 8'd0, 8'd0, DIR_COL_UP, 16'd49153, 3'd0), got);
        send_item(make_item(OP_INTERACT, 8'd0, 8'd0, DIR_COL_UP, 16'hFFFF, 3'd0), got);
        // predation at the lower threshold: species 1 eats species 3
        send_item(make_item(OP_INTERACT, 8'd0, 8'd0, DIR_ROW_UP, 16'd32768, 3'd0), got);
        // move into an empty cell across the row wrap, and back
        send_item(make_item(OP_INTERACT, 8'd0, 8'd0, DIR_ROW_DOWN, 16'd0, 3'd0), got);
        send_item(make_item(OP_INTERACT, 8'd255, 8'd0, DIR_ROW_UP, 16'd32767, 3'd0), got);
        // birth across the column wrap
        send_item(make_item(OP_INTERACT, 8'd0, 8'd0, DIR_COL_DOWN, 16'd60000, 3'd0), got);
        // species 4 may not eat species 3
        send_item(make_item(OP_WRITE, 8'd255, 8'd254, DIR_ROW_UP, 16'd0, 3'd3), got);
        send_item(make_item(OP_INTERACT, 8'd255, 8'd255, DIR_COL_DOWN, 16'd45000, 3'd0), got);
        // species 4 eats species 1 across the row wrap
        send_item(make_item(OP_INTERACT, 8'd255, 8'd255, DIR_ROW_UP, 16'd40000, 3'd0), got);
        // move across the column wrap
        send_item(make_item(OP_INTERACT, 8'd255, 8'd255, DIR_COL_UP, 16'd0, 3'd0), got);
    endtask

    // One register setting and one stretch of random traffic around a hot
    // window; hold off halfway through until everything has come back.
    task automatic run_phase(input logic [15:0] mob, input logic [15:0] pred,
                             input logic [15:0] tbl, input logic [7:0] hot_r,
                             input logic [7:0] hot_c, input int target);
        t_outcome got;
        int       counted;
        int       sent;
        logic     paused;
        wait_drained();
        write_reg(CFG_MOBILITY, mob);
        write_reg(CFG_PREDATION, pred);
        write_reg(CFG_TABLE, tbl);
        counted = 0;
        sent    = 0;
        paused  = 1'b0;
        while (counted < target) begin
            // mix calm stretches in with paced ones
            if (sent % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
            if (!paused && counted >= target / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            send_item(random_item(hot_r, hot_c), got);
            sent++;
            // beats with an empty active cell do not count
            if (got != OUT_IGNORED) counted++;
        end
    endtask

    task automatic test_random_mix();
        int per_phase;
        per_phase = RANDOM_ITEMS / PHASE_COUNT;
        run_phase(MOB_RESET, PRED_RESET, TABLE_RESET, 8'd254, 8'd254, per_phase);
        run_phase(16'd0, 16'hFFFF, 16'hFFFF, 8'd0, 8'd0, per_phase);
        run_phase(16'hFFFF, 16'hFFFF, 16'h0000, 8'd127, 8'd255, per_phase);
        run_phase(16'd0, 16'd0, 16'hFFFF, 8'd255, 8'd0, per_phase);
        // the spare index must not disturb any register
        wait_drained();
        write_reg(CFG_SPARE, 16'($urandom_range(0, 65535)));
        run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), per_phase);
        run_phase(16'd20000, 16'd30000, 16'($urandom_range(0, 65535)),
                  8'd253, 8'd1, per_phase);
        i_in_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        int k;
        lattice_clear();
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_operation   <= OP_READ;
        i_row         <= 8'd0;
        i_col         <= 8'd0;
        i_direction   <= DIR_ROW_UP;
        i_action_draw <= 16'd0;
        i_new_value   <= CELL_EMPTY;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_MOBILITY;
        i_cfg_data    <= 16'd0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // the clearing pass after reset shows up as input stall; the first
        // beat simply waits it out
        idle_on = 1'b1;
        test_cell_access();
        test_interact_directed();
        test_random_mix();

        // wait for the tail of the traffic, bounded
        for (k = 0; k < DRAIN_LIMIT && pending_q.size() != 0; k++) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_q.size() != 0)
            report($sformatf("%0d predicted beats never arrived", pending_q.size()));

        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
